@@ rtl/motor_position_p_regulator_macros.svh @@
// assertion macros for the motor position regulator checker
// no dependencies; included by the checker file
`ifndef MOTOR_POSITION_P_REGULATOR_MACROS_SVH
`define MOTOR_POSITION_P_REGULATOR_MACROS_SVH

// same-cycle implication, disabled while in reset
`define MPPR_ASSERT_NOW(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("mppr assertion failed");

// next-cycle implication, disabled while in reset
`define MPPR_ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("mppr assertion failed");

`endif

@@ rtl/mppr_pkg.sv @@
// types and constants shared by the motor position regulator modules
// no dependencies
`default_nettype none

package mppr_pkg;

    // action codes
    localparam logic [1:0] ACT_PULSE  = 2'd0;
    localparam logic [1:0] ACT_TICK   = 2'd1;
    localparam logic [1:0] ACT_TARGET = 2'd2;
    localparam logic [1:0] ACT_ZERO   = 2'd3;

    // drive direction codes
    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_GAIN    = 2'd0;
    localparam logic [1:0] CFG_PWM_MAX = 2'd1;
    localparam logic [1:0] CFG_PWM_MIN = 2'd2;
    localparam logic [1:0] CFG_PERIOD  = 2'd3;

    // configuration reset values
    localparam logic [7:0] GAIN_RESET    = 8'd4;
    localparam logic [7:0] PWM_MAX_RESET = 8'd254;
    localparam logic [7:0] PWM_MIN_RESET = 8'd60;
    localparam logic [7:0] PERIOD_RESET  = 8'd2;

    typedef struct packed {
        logic [7:0] gain;
        logic [7:0] pwm_max;
        logic [7:0] pwm_min;
        logic [7:0] period;
    } cfg_t;

    typedef struct packed {
        logic [1:0] dir;
        logic [7:0] duty;
    } drive_t;

    typedef struct packed {
        logic [7:0]         duty;
        logic [1:0]         drive_dir;
        logic               led_on;
        logic signed [31:0] position;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/mppr_regulator.sv @@
// proportional regulator: error, gain, clamp and minimum drive in one pass
// depends on mppr_pkg
`default_nettype none

module mppr_regulator
    import mppr_pkg::*;
#(
    parameter int POS_BITS = 32
)
(
    input  logic signed [POS_BITS-1:0] pos,
    input  logic signed [31:0]         target,
    input  cfg_t                       cfg,
    output drive_t                     drive
);

    localparam int ERR_BITS = ((POS_BITS > 32) ? POS_BITS : 32) + 1;

    logic signed [ERR_BITS-1:0] err;
    logic [ERR_BITS-1:0]        mag;
    logic                       big;
    logic [15:0]                prod;
    logic [7:0]                 clamped;
    logic [7:0]                 level;

    always_comb
    begin
        err  = ERR_BITS'(pos) - ERR_BITS'(target);
        mag  = err[ERR_BITS-1] ? ERR_BITS'(-err) : ERR_BITS'(err);
        // any error of 256 or more with nonzero gain saturates, so only the low byte is multiplied
        big  = |mag[ERR_BITS-1:8];
        prod = 16'(mag[7:0]) * 16'(cfg.gain);

        if (cfg.gain == 8'd0)
            clamped = 8'd0;
        else if (big || (prod > 16'(cfg.pwm_max)))
            clamped = cfg.pwm_max;
        else
            clamped = prod[7:0];

        if ((clamped != 8'd0) && (clamped < cfg.pwm_min))
            level = cfg.pwm_min;
        else
            level = clamped;

        drive.duty = level;
        if (level == 8'd0)
            drive.dir = DIR_STOP;
        else if (err[ERR_BITS-1])
            drive.dir = DIR_REV;
        else
            drive.dir = DIR_FWD;
    end

endmodule

`default_nettype wire

@@ rtl/motor_position_p_regulator.sv @@
// top level of the motor position regulator: state, handshakes, config port
// depends on mppr_pkg and mppr_regulator
`default_nettype none

// Valve-motor position servo. One input word is accepted per clock while in_ready is
// high; its result word is registered into the result register, or into the skid
// register while the output is stalled. The position, target, tick count and drive
// state update in the accepting cycle, so the rate of one word per clock is set by the
// combinational regulator path (error subtract, 8x8 multiply, clamp and minimum raise).
// The output side has a result register plus one skid register, so input keeps flowing
// for one extra word while stalled. Configuration is written via cfg_en/cfg_index/cfg_data.

module motor_position_p_regulator
    import mppr_pkg::*;
#(
    parameter int POS_BITS = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         action,
    input  logic signed [31:0] target,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         duty,
    output logic [1:0]         drive_dir,
    output logic               led_on,
    output logic signed [31:0] position,
    input  logic               cfg_en,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data
);

    cfg_t                       cfg_reg;
    logic signed [POS_BITS-1:0] pos_reg, pos_next;
    logic signed [31:0]         target_reg, target_next;
    logic [7:0]                 tick_reg, tick_next, tick_inc;
    drive_t                     drv_reg, drv_next, reg_drive;
    result_t                    out_reg, skid_reg, res_next;
    logic                       out_valid_reg, skid_valid_reg;
    logic                       acc, take;

    mppr_regulator #(.POS_BITS(POS_BITS)) u_reg (
        .pos    (pos_reg),
        .target (target_reg),
        .cfg    (cfg_reg),
        .drive  (reg_drive)
    );

    assign in_ready = !skid_valid_reg;
    assign acc      = in_valid && in_ready;
    assign take     = out_valid_reg && out_ready;

    always_comb
    begin
        pos_next    = pos_reg;
        target_next = target_reg;
        tick_next   = tick_reg;
        drv_next    = drv_reg;
        tick_inc    = tick_reg + 8'd1;
        case (action)
            ACT_PULSE:
            begin
                if (drv_reg.dir == DIR_REV)
                    pos_next = pos_reg + POS_BITS'(1);
                else
                    pos_next = pos_reg - POS_BITS'(1);
            end
            ACT_TICK:
            begin
                // a period of zero behaves like one
                if (tick_inc >= cfg_reg.period)
                begin
                    tick_next = 8'd0;
                    drv_next  = reg_drive;
                end
                else
                    tick_next = tick_inc;
            end
            ACT_TARGET: target_next = target;
            ACT_ZERO:   pos_next = '0;
            default:    pos_next = pos_reg;
        endcase

        res_next.drive_dir = drv_next.dir;
        res_next.led_on    = (drv_next.dir != DIR_STOP);
        res_next.duty      = (drv_next.dir == DIR_STOP) ? 8'd0 : drv_next.duty;
        res_next.position  = 32'(pos_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain    <= GAIN_RESET;
            cfg_reg.pwm_max <= PWM_MAX_RESET;
            cfg_reg.pwm_min <= PWM_MIN_RESET;
            cfg_reg.period  <= PERIOD_RESET;
        end
        else if (cfg_en)
        begin
            case (cfg_index)
                CFG_GAIN:    cfg_reg.gain    <= cfg_data;
                CFG_PWM_MAX: cfg_reg.pwm_max <= cfg_data;
                CFG_PWM_MIN: cfg_reg.pwm_min <= cfg_data;
                CFG_PERIOD:  cfg_reg.period  <= cfg_data;
                default:     cfg_reg.gain    <= cfg_reg.gain;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            target_reg <= '0;
            tick_reg   <= 8'd0;
            drv_reg    <= '{dir: DIR_STOP, duty: 8'd0};
        end
        else if (acc)
        begin
            pos_reg    <= pos_next;
            target_reg <= target_next;
            tick_reg   <= tick_next;
            drv_reg    <= drv_next;
        end
    end

    // result register with one skid entry behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (acc)
        begin
            if (!out_valid_reg || take)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
                out_reg <= skid_reg;
        end
        else if (acc)
        begin
            if (!out_valid_reg || take)
                out_reg <= res_next;
            else
                skid_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign duty      = out_reg.duty;
    assign drive_dir = out_reg.drive_dir;
    assign led_on    = out_reg.led_on;
    assign position  = out_reg.position;

endmodule

`default_nettype wire

@@ rtl/mppr_checker.sv @@
// port-level checker for the motor position regulator, bound to the top level
// depends on mppr_pkg and motor_position_p_regulator_macros.svh
`default_nettype none

`include "motor_position_p_regulator_macros.svh"

module mppr_checker
    import mppr_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [7:0]         duty,
    input logic [1:0]         drive_dir,
    input logic               led_on,
    input logic signed [31:0] position
);

    // a stalled result word holds
    `MPPR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(duty) && $stable(drive_dir) && $stable(led_on) && $stable(position))

    // led follows the drive direction
    `MPPR_ASSERT_NOW(a_led_dir, clk, rst_n, out_valid, led_on == (drive_dir != DIR_STOP))

    // stopped means zero duty, driven means nonzero duty
    `MPPR_ASSERT_NOW(a_duty_dir, clk, rst_n, out_valid, (drive_dir == DIR_STOP) == (duty == 8'd0))

    // a result only shows up after an input word was taken
    `MPPR_ASSERT_NOW(a_no_spurious, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready))

endmodule

bind motor_position_p_regulator mppr_checker u_mppr_checker (.*);

`default_nettype wire
